FILE: design/cpbf_pkg.sv
// shared widths, result status codes and the distance helper for the closest pair block
`timescale 1ns / 1ps
`default_nettype none
package cpbf_pkg;

    localparam int COORD_FIELD_W = 10;
    localparam int INDEX_FIELD_W = 4;
    localparam int DIST_FIELD_W  = 21;
    localparam int STATUS_W      = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_FEW  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // absolute difference of two coordinates
    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return d;
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/cpbf_cell.sv
// one cell of the search chain: holds one point and scores passing probes against it
`timescale 1ns / 1ps
`default_nettype none
module cpbf_cell #(
    parameter int COORD_W  = 10,
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load_en,
    input  wire logic [COORD_W-1:0]   load_x,
    input  wire logic [COORD_W-1:0]   load_y,
    output logic [COORD_W-1:0]        point_x,
    output logic [COORD_W-1:0]        point_y,
    input  wire logic                 in_valid,
    input  wire logic [IDX_W-1:0]     in_idx,
    input  wire logic [COORD_W-1:0]   in_x,
    input  wire logic [COORD_W-1:0]   in_y,
    input  wire logic [2*COORD_W:0]   in_dist,
    input  wire logic [IDX_W-1:0]     in_bj,
    input  wire logic [COORD_W-1:0]   in_bx,
    input  wire logic [COORD_W-1:0]   in_by,
    output logic                      out_valid,
    output logic [IDX_W-1:0]          out_idx,
    output logic [COORD_W-1:0]        out_x,
    output logic [COORD_W-1:0]        out_y,
    output logic [2*COORD_W:0]        out_dist,
    output logic [IDX_W-1:0]          out_bj,
    output logic [COORD_W-1:0]        out_bx,
    output logic [COORD_W-1:0]        out_by
);
    import cpbf_pkg::*;

    localparam int DIST_W = 2 * COORD_W + 1;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [COORD_W-1:0]   px_reg, py_reg;
    logic [COORD_W-1:0]   dx, dy;
    logic [2*COORD_W-1:0] sqx, sqy;
    logic [DIST_W-1:0]    d_next;

    logic                 s1_valid_reg;
    logic                 s1_elig_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic [COORD_W-1:0]   s1_x_reg, s1_y_reg;
    logic [DIST_W-1:0]    s1_dist_reg, s1_d_reg;
    logic [IDX_W-1:0]     s1_bj_reg;
    logic [COORD_W-1:0]   s1_bx_reg, s1_by_reg;

    logic                 s2_valid_reg;
    logic [IDX_W-1:0]     s2_idx_reg;
    logic [COORD_W-1:0]   s2_x_reg, s2_y_reg;
    logic [DIST_W-1:0]    s2_dist_reg;
    logic [IDX_W-1:0]     s2_bj_reg;
    logic [COORD_W-1:0]   s2_bx_reg, s2_by_reg;

    logic                 take;

    always_comb begin
        dx     = COORD_W'(abs_diff(16'(in_x), 16'(px_reg)));
        dy     = COORD_W'(abs_diff(16'(in_y), 16'(py_reg)));
        sqx    = dx * dx;
        sqy    = dy * dy;
        d_next = DIST_W'(sqx) + DIST_W'(sqy);
    end

    // strictly smaller keeps the earlier pair on a tie
    assign take = s1_elig_reg && (s1_d_reg < s1_dist_reg);

    always_ff @(posedge aclk) begin
        if (load_en) begin
            px_reg <= load_x;
            py_reg <= load_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_elig_reg <= MY_IDX < in_idx;
        s1_idx_reg  <= in_idx;
        s1_x_reg    <= in_x;
        s1_y_reg    <= in_y;
        s1_dist_reg <= in_dist;
        s1_d_reg    <= d_next;
        s1_bj_reg   <= in_bj;
        s1_bx_reg   <= in_bx;
        s1_by_reg   <= in_by;

        s2_idx_reg  <= s1_idx_reg;
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
        if (take) begin
            s2_dist_reg <= s1_d_reg;
            s2_bj_reg   <= MY_IDX;
            s2_bx_reg   <= px_reg;
            s2_by_reg   <= py_reg;
        end else begin
            s2_dist_reg <= s1_dist_reg;
            s2_bj_reg   <= s1_bj_reg;
            s2_bx_reg   <= s1_bx_reg;
            s2_by_reg   <= s1_by_reg;
        end
    end

    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign out_valid = s2_valid_reg;
    assign out_idx   = s2_idx_reg;
    assign out_x     = s2_x_reg;
    assign out_y     = s2_y_reg;
    assign out_dist  = s2_dist_reg;
    assign out_bj    = s2_bj_reg;
    assign out_bx    = s2_bx_reg;
    assign out_by    = s2_by_reg;

endmodule
`default_nettype wire

FILE: design/closest_pair_brute_force.sv
// top level of the brute-force closest pair search over a chain of point cells
`timescale 1ns / 1ps
`default_nettype none
// Points enter one item per cycle while loading and each is kept in its own cell of a chain of
// MAX_POINTS cells. The item with tlast starts the search: one probe per stored point i (i from 1
// to n-1) enters the chain per cycle and walks all cells, each cell scoring the probe against its
// point j < i through its s1 and s2 registers and keeping the better pair. The input is held off
// during the search and until the result enters the output register; a finished result waits in
// the output register while the next set loads. Status 1 means fewer than two points (other
// fields zero), status 2 means points beyond MAX_POINTS were dropped and the pair is taken over
// the stored ones.
module closest_pair_brute_force #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 10
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // point_x, point_y
    input  wire logic [cpbf_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // first_index, second_index, first_x, first_y, second_x, second_y, squared_distance
    output logic [cpbf_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // status
    output logic [cpbf_pkg::STATUS_W-1:0]          m_tuser
);
    import cpbf_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIST_W = 2 * COORD_BITS + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic [CNT_W-1:0]    launch_reg;
    logic [CNT_W-1:0]    exit_reg;

    logic [IDX_W-1:0]    best_i_reg, best_j_reg;
    logic [COORD_BITS-1:0] best_ix_reg, best_iy_reg, best_jx_reg, best_jy_reg;
    logic [DIST_W-1:0]   best_d_reg;

    logic                out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    status_t             out_status_reg;

    logic                accept;
    logic                full;
    logic [CNT_W-1:0]    count_after;
    logic [COORD_BITS-1:0] in_x, in_y;
    logic                inject;
    logic [IDX_W-1:0]    launch_idx;
    logic                out_free;

    logic                  ch_valid [MAX_POINTS+1];
    logic [IDX_W-1:0]      ch_idx   [MAX_POINTS+1];
    logic [COORD_BITS-1:0] ch_x     [MAX_POINTS+1];
    logic [COORD_BITS-1:0] ch_y     [MAX_POINTS+1];
    logic [DIST_W-1:0]     ch_dist  [MAX_POINTS+1];
    logic [IDX_W-1:0]      ch_bj    [MAX_POINTS+1];
    logic [COORD_BITS-1:0] ch_bx    [MAX_POINTS+1];
    logic [COORD_BITS-1:0] ch_by    [MAX_POINTS+1];

    logic [COORD_BITS-1:0] cell_x [MAX_POINTS];
    logic [COORD_BITS-1:0] cell_y [MAX_POINTS];

    assign s_tready    = (state_reg == ST_LOAD);
    assign accept      = s_tvalid && s_tready;
    assign full        = (count_reg == FULL_CNT);
    assign count_after = full ? count_reg : count_reg + 1'b1;
    assign in_x        = COORD_BITS'(s_tdata[COORD_FIELD_W-1:0]);
    assign in_y        = COORD_BITS'(s_tdata[2*COORD_FIELD_W-1:COORD_FIELD_W]);
    assign out_free    = !out_valid_reg || m_tready;

    // probe launch for point i
    assign inject     = (state_reg == ST_SEARCH) && (launch_reg < count_reg);
    assign launch_idx = launch_reg[IDX_W-1:0];

    always_comb begin
        ch_valid[0] = inject;
        ch_idx[0]   = launch_idx;
        ch_x[0]     = cell_x[launch_idx];
        ch_y[0]     = cell_y[launch_idx];
        ch_dist[0]  = '1;
        ch_bj[0]    = '0;
        ch_bx[0]    = '0;
        ch_by[0]    = '0;
    end

    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        logic load_en;
        assign load_en = accept && !full && (count_reg[IDX_W-1:0] == IDX_W'(k));

        cpbf_cell #(
            .COORD_W  (COORD_BITS),
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load_en   (load_en),
            .load_x    (in_x),
            .load_y    (in_y),
            .point_x   (cell_x[k]),
            .point_y   (cell_y[k]),
            .in_valid  (ch_valid[k]),
            .in_idx    (ch_idx[k]),
            .in_x      (ch_x[k]),
            .in_y      (ch_y[k]),
            .in_dist   (ch_dist[k]),
            .in_bj     (ch_bj[k]),
            .in_bx     (ch_bx[k]),
            .in_by     (ch_by[k]),
            .out_valid (ch_valid[k+1]),
            .out_idx   (ch_idx[k+1]),
            .out_x     (ch_x[k+1]),
            .out_y     (ch_y[k+1]),
            .out_dist  (ch_dist[k+1]),
            .out_bj    (ch_bj[k+1]),
            .out_bx    (ch_bx[k+1]),
            .out_by    (ch_by[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            launch_reg    <= '0;
            exit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_FINISH) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (accept) begin
                        count_reg <= count_after;
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            launch_reg <= CNT_W'(1);
                            exit_reg   <= '0;
                            best_d_reg <= '1;
                            state_reg  <= (count_after < TWO_CNT) ? ST_FINISH : ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (inject) begin
                        launch_reg <= launch_reg + 1'b1;
                    end
                    // probes leave in ascending i, so strictly smaller keeps search order
                    if (ch_valid[MAX_POINTS]) begin
                        exit_reg <= exit_reg + 1'b1;
                        if (ch_dist[MAX_POINTS] < best_d_reg) begin
                            best_d_reg  <= ch_dist[MAX_POINTS];
                            best_i_reg  <= ch_idx[MAX_POINTS];
                            best_j_reg  <= ch_bj[MAX_POINTS];
                            best_ix_reg <= ch_x[MAX_POINTS];
                            best_iy_reg <= ch_y[MAX_POINTS];
                            best_jx_reg <= ch_bx[MAX_POINTS];
                            best_jy_reg <= ch_by[MAX_POINTS];
                        end
                    end
                    if (exit_reg == count_reg - 1'b1) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        if (count_reg < TWO_CNT) begin
                            out_data_reg   <= '0;
                            out_status_reg <= STATUS_TOO_FEW;
                        end else begin
                            out_data_reg <= OUT_TDATA_W'({
                                DIST_FIELD_W'(best_d_reg),
                                COORD_FIELD_W'(best_jy_reg),
                                COORD_FIELD_W'(best_jx_reg),
                                COORD_FIELD_W'(best_iy_reg),
                                COORD_FIELD_W'(best_ix_reg),
                                INDEX_FIELD_W'(best_j_reg),
                                INDEX_FIELD_W'(best_i_reg)});
                            out_status_reg <= ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
                        end
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("point count above store depth");

    a_launch_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> launch_reg <= count_reg)
        else $error("probe launched past last stored point");

    a_exit_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        ch_valid[MAX_POINTS] |-> state_reg == ST_SEARCH)
        else $error("probe left the chain outside the search");

    a_best_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && count_reg >= TWO_CNT) |-> best_d_reg != '1)
        else $error("search finished without a candidate pair");

    a_no_load_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |=> count_reg == $past(count_reg))
        else $error("stored point count changed during the search");

endmodule
`default_nettype wire
